[sv/dhoat_pkg.sv]
// ----------------------------------------------------------------------------
// dhoat_pkg
// Types, codes and sizes shared by the double-hash table controller and datapath.
// ----------------------------------------------------------------------------
package dhoat_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int SIZE_W    = IDX_W + 1;
    localparam int KEY_W     = 34;
    localparam int VAL_W     = 64;
    localparam int CNT_W     = $clog2(KEY_W);
    localparam int IN_W      = 104;
    localparam int OUT_W     = 80;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        SLOT_EMPTY    = 2'd0,
        SLOT_OCCUPIED = 2'd1,
        SLOT_DELETED  = 2'd2,
        SLOT_UNUSED   = 2'd3
    } slot_t;

    typedef enum logic [1:0] {
        RES_SUCCESS   = 2'd0,
        RES_FAILURE   = 2'd1,
        RES_FOUND     = 2'd2,
        RES_NOT_FOUND = 2'd3
    } result_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_KEY,
        ST_MID,
        ST_DIV_QUO,
        ST_HASHED,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic    clear;
        logic    load;
        logic    div_step;
        logic    div_mid;
        logic    div_end;
        logic    advance;
        logic    write_ins;
        logic    write_del;
        logic    res_load;
        logic    res_hit;
        result_t res_status;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic    clear_last;
        logic    div_last;
        opcode_t op;
        logic    count_full;
        logic    count_zero;
        slot_t   rd_state;
        logic    key_match;
        logic    wrap;
        logic    out_busy;
    } sts_t;

endpackage

[sv/dhoat_datapath.sv]
// ----------------------------------------------------------------------------
// dhoat_datapath
// Request registers, shared bit-serial divider, probe index, slot memories and
// result/output registers.
// ----------------------------------------------------------------------------
module dhoat_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  dhoat_pkg::cmd_t                cmd,
    output dhoat_pkg::sts_t                sts,
    input  logic [dhoat_pkg::SIZE_W-1:0]   n,
    input  logic [dhoat_pkg::IN_W-1:0]     in_data,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [dhoat_pkg::OUT_W-1:0]    m_tdata
);

    localparam int IDX_W  = dhoat_pkg::IDX_W;
    localparam int SIZE_W = dhoat_pkg::SIZE_W;
    localparam int KEY_W  = dhoat_pkg::KEY_W;
    localparam int VAL_W  = dhoat_pkg::VAL_W;
    localparam int CNT_W  = dhoat_pkg::CNT_W;

    dhoat_pkg::opcode_t  op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VAL_W-1:0]    pay_reg;

    logic [KEY_W-1:0]    dvd_reg, dvd_next;
    logic [SIZE_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]    dcnt_reg;
    logic [SIZE_W:0]     trial;
    logic                ge;

    logic [IDX_W-1:0]    start_reg;
    logic [SIZE_W-1:0]   step_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic [SIZE_W:0]     sum;

    logic [IDX_W-1:0]    clr_reg;
    logic [SIZE_W-1:0]   count_reg;

    logic [1:0]          state_mem [dhoat_pkg::MAX_SLOTS];
    logic [KEY_W-1:0]    key_mem   [dhoat_pkg::MAX_SLOTS];
    logic [VAL_W-1:0]    val_mem   [dhoat_pkg::MAX_SLOTS];
    logic [1:0]          rd_state_reg;
    logic [KEY_W-1:0]    rd_key_reg;
    logic [VAL_W-1:0]    rd_val_reg;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [1:0]          wr_state;

    dhoat_pkg::result_t  res_status_reg;
    logic [IDX_W-1:0]    res_slot_reg;
    logic [VAL_W-1:0]    res_val_reg;
    logic                out_valid_reg;
    logic [dhoat_pkg::OUT_W-1:0] out_data_reg;

    // divider step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[KEY_W-1]};
        ge       = (trial >= {1'b0, n});
        rem_next = ge ? SIZE_W'(trial - {1'b0, n}) : SIZE_W'(trial);
        dvd_next = {dvd_reg[KEY_W-2:0], ge};
    end

    always_comb
    begin
        sum = {2'b00, idx_reg} + {1'b0, step_reg};
        if (sum >= {1'b0, n})
        begin
            sum = sum - {1'b0, n};
        end
        idx_next = sum[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= dhoat_pkg::opcode_t'(in_data[1:0]);
            key_reg <= in_data[KEY_W+1:2];
            pay_reg <= in_data[KEY_W+VAL_W+1:KEY_W+2];
            dvd_reg <= in_data[KEY_W+1:2];
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
        else if (cmd.div_mid)
        begin
            start_reg <= rem_reg[IDX_W-1:0];
            rem_reg   <= '0;
        end
        else if (cmd.div_end)
        begin
            step_reg <= rem_reg | SIZE_W'(1);
            idx_reg  <= start_reg;
        end
        else if (cmd.advance)
        begin
            idx_reg <= idx_next;
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_slot_reg   <= cmd.res_hit ? idx_reg : '0;
            res_val_reg    <= cmd.res_hit ? rd_val_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg      <= '0;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load || cmd.div_mid)
            begin
                dcnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg + CNT_W'(1);
            end
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (cmd.write_ins)
            begin
                count_reg <= count_reg + SIZE_W'(1);
            end
            else if (cmd.write_del)
            begin
                count_reg <= count_reg - SIZE_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {4'b0000, res_val_reg, res_slot_reg, res_status_reg};
        end
    end

    always_comb
    begin
        wr_en    = cmd.clear | cmd.write_ins | cmd.write_del;
        wr_addr  = cmd.clear ? clr_reg : idx_reg;
        wr_state = cmd.clear ? dhoat_pkg::SLOT_EMPTY :
                   cmd.write_ins ? dhoat_pkg::SLOT_OCCUPIED : dhoat_pkg::SLOT_DELETED;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            state_mem[wr_addr] <= wr_state;
        end
        if (cmd.write_ins)
        begin
            key_mem[idx_reg] <= key_reg;
            val_mem[idx_reg] <= pay_reg;
        end
        rd_state_reg <= state_mem[idx_reg];
        rd_key_reg   <= key_mem[idx_reg];
        rd_val_reg   <= val_mem[idx_reg];
    end

    always_comb
    begin
        sts.clear_last = (clr_reg == IDX_W'(dhoat_pkg::MAX_SLOTS - 1));
        sts.div_last   = (dcnt_reg == CNT_W'(KEY_W - 1));
        sts.op         = op_reg;
        sts.count_full = (count_reg >= n);
        sts.count_zero = (count_reg == '0);
        sts.rd_state   = dhoat_pkg::slot_t'(rd_state_reg);
        sts.key_match  = (rd_key_reg == key_reg);
        sts.wrap       = (idx_next == start_reg);
        sts.out_busy   = out_valid_reg & ~m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[sv/dhoat_ctrl.sv]
// ----------------------------------------------------------------------------
// dhoat_ctrl
// Sequencer: memory clear after reset, two divider passes, probe walk, result.
// ----------------------------------------------------------------------------
module dhoat_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  dhoat_pkg::sts_t sts,
    output dhoat_pkg::cmd_t cmd
);

    dhoat_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dhoat_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dhoat_pkg::ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = dhoat_pkg::ST_IDLE;
                end
            end
            dhoat_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = dhoat_pkg::ST_DIV_KEY;
                end
            end
            dhoat_pkg::ST_DIV_KEY:
            begin
                if (sts.div_last)
                begin
                    state_next = dhoat_pkg::ST_MID;
                end
            end
            dhoat_pkg::ST_MID:
            begin
                state_next = dhoat_pkg::ST_DIV_QUO;
            end
            dhoat_pkg::ST_DIV_QUO:
            begin
                if (sts.div_last)
                begin
                    state_next = dhoat_pkg::ST_HASHED;
                end
            end
            dhoat_pkg::ST_HASHED:
            begin
                priority if (sts.op == dhoat_pkg::OP_NONE)
                begin
                    state_next = dhoat_pkg::ST_DONE;
                end
                else if (sts.op == dhoat_pkg::OP_INSERT && sts.count_full)
                begin
                    state_next = dhoat_pkg::ST_DONE;
                end
                else if (sts.op != dhoat_pkg::OP_INSERT && sts.count_zero)
                begin
                    state_next = dhoat_pkg::ST_DONE;
                end
                else
                begin
                    state_next = dhoat_pkg::ST_READ;
                end
            end
            dhoat_pkg::ST_READ:
            begin
                state_next = dhoat_pkg::ST_CHECK;
            end
            dhoat_pkg::ST_CHECK:
            begin
                priority if (sts.op == dhoat_pkg::OP_INSERT)
                begin
                    if (sts.rd_state == dhoat_pkg::SLOT_OCCUPIED && !sts.key_match
                        && !sts.wrap)
                    begin
                        state_next = dhoat_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = dhoat_pkg::ST_DONE;
                    end
                end
                else
                begin
                    if (sts.rd_state == dhoat_pkg::SLOT_EMPTY
                        || (sts.rd_state == dhoat_pkg::SLOT_OCCUPIED && sts.key_match)
                        || sts.wrap)
                    begin
                        state_next = dhoat_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = dhoat_pkg::ST_READ;
                    end
                end
            end
            dhoat_pkg::ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    state_next = dhoat_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dhoat_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.res_status = dhoat_pkg::RES_FAILURE;
        s_tready       = 1'b0;
        unique case (state_reg)
            dhoat_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            dhoat_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            dhoat_pkg::ST_DIV_KEY, dhoat_pkg::ST_DIV_QUO:
            begin
                cmd.div_step = 1'b1;
            end
            dhoat_pkg::ST_MID:
            begin
                cmd.div_mid = 1'b1;
            end
            dhoat_pkg::ST_HASHED:
            begin
                cmd.div_end  = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_status = (sts.op == dhoat_pkg::OP_SEARCH) ?
                                 dhoat_pkg::RES_NOT_FOUND : dhoat_pkg::RES_FAILURE;
            end
            dhoat_pkg::ST_READ:
            begin
            end
            dhoat_pkg::ST_CHECK:
            begin
                cmd.res_load = 1'b1;
                priority if (sts.op == dhoat_pkg::OP_INSERT)
                begin
                    priority if (sts.rd_state != dhoat_pkg::SLOT_OCCUPIED)
                    begin
                        cmd.write_ins  = 1'b1;
                        cmd.res_status = dhoat_pkg::RES_SUCCESS;
                    end
                    else if (sts.key_match || sts.wrap)
                    begin
                        cmd.res_status = dhoat_pkg::RES_FAILURE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
                else
                begin
                    priority if (sts.rd_state == dhoat_pkg::SLOT_EMPTY)
                    begin
                        cmd.res_status = (sts.op == dhoat_pkg::OP_SEARCH) ?
                                         dhoat_pkg::RES_NOT_FOUND : dhoat_pkg::RES_FAILURE;
                    end
                    else if (sts.rd_state == dhoat_pkg::SLOT_OCCUPIED && sts.key_match)
                    begin
                        if (sts.op == dhoat_pkg::OP_SEARCH)
                        begin
                            cmd.res_hit    = 1'b1;
                            cmd.res_status = dhoat_pkg::RES_FOUND;
                        end
                        else
                        begin
                            cmd.write_del  = 1'b1;
                            cmd.res_status = dhoat_pkg::RES_SUCCESS;
                        end
                    end
                    else if (sts.wrap)
                    begin
                        cmd.res_status = dhoat_pkg::RES_NOT_FOUND;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            dhoat_pkg::ST_DONE:
            begin
                cmd.out_load = ~sts.out_busy;
            end
            default:
            begin
            end
        endcase
    end

endmodule

[sv/double_hash_open_address_table_unit.sv]
// ----------------------------------------------------------------------------
// double_hash_open_address_table_unit
// Keyed table with open addressing and double hashing, one result per request.
// ----------------------------------------------------------------------------
// After reset the slot-state memory is swept to empty, and no request is
// taken during the sweep. A request then runs two passes of the bit-serial
// divider by the table size, then one registered memory read per probed
// slot, and then hands the word to the output register. Opcode 3 and the
// full/empty early answers skip the probe walk but not the divider.
module double_hash_open_address_table_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // opcode[1:0], key[35:2], payload[99:36]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,   // status[1:0], slot_index[11:2], found_value[75:12]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [dhoat_pkg::SIZE_W-1:0] tsize_reg;
    logic [dhoat_pkg::SIZE_W-1:0] n;
    dhoat_pkg::cmd_t cmd;
    dhoat_pkg::sts_t sts;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tsize_reg <= dhoat_pkg::SIZE_W'(dhoat_pkg::MAX_SLOTS);
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            tsize_reg <= pwdata[dhoat_pkg::SIZE_W-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {{(32 - dhoat_pkg::SIZE_W){1'b0}}, tsize_reg};

    always_comb
    begin
        priority if (tsize_reg == '0)
        begin
            n = dhoat_pkg::SIZE_W'(1);
        end
        else if (tsize_reg > dhoat_pkg::SIZE_W'(dhoat_pkg::MAX_SLOTS))
        begin
            n = dhoat_pkg::SIZE_W'(dhoat_pkg::MAX_SLOTS);
        end
        else
        begin
            n = tsize_reg;
        end
    end

    dhoat_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dhoat_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .n        (n),
        .in_data  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

[sv/dhoat_checker.sv]
// ----------------------------------------------------------------------------
// dhoat_checker
// Port-level checks on the double-hash table unit.
// ----------------------------------------------------------------------------
module dhoat_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [79:0]  m_tdata,
    input logic         pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while one is in work");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != dhoat_pkg::RES_FOUND |-> m_tdata[75:2] == '0)
        else $error("slot or value set on a non-found answer");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[79:76] == 4'd0)
        else $error("padding bits set");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind double_hash_open_address_table_unit dhoat_checker u_dhoat_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double-hash open-address table unit: a directed
// table of requests, then random insert/search/remove traffic over a small
// key pool, each result compared field by field with a behavioural table.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dhoat_pkg::*;

    typedef struct {
        opcode_t      op;
        logic [33:0]  key;
        logic [63:0]  payload;
        logic         known;
        result_t      status;
        logic [9:0]   slot;
        logic [63:0]  value;
    } request_t;

    typedef struct {
        result_t      status;
        logic [9:0]   slot;
        logic [63:0]  value;
    } answer_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [79:0]  m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    slot_t        slot_mem [MAX_SLOTS];
    logic [33:0]  key_mem  [MAX_SLOTS];
    logic [63:0]  val_mem  [MAX_SLOTS];
    int unsigned  live_count;
    logic [10:0]  size_reg;

    answer_t      pending_answers[$];
    int           errors;
    int           send_idle;
    int           recv_idle;
    longint       cycle_count = 0;
    logic [33:0]  key_pool[$];

    localparam int CYCLE_LIMIT = 4000000;

    double_hash_open_address_table_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic answer_t table_lookup(opcode_t op, logic [33:0] key,
                                             logic [63:0] payload);
        answer_t     a;
        int unsigned n;
        int unsigned start;
        int unsigned stride;
        int unsigned idx;
        int unsigned guard;
        logic        hit;
        a.status = RES_FAILURE;
        a.slot   = '0;
        a.value  = '0;
        hit      = 1'b0;
        n = (size_reg == 0) ? 1 : (size_reg > MAX_SLOTS) ? MAX_SLOTS : size_reg;
        start  = key % n;
        stride = (key / n) % n;
        if (stride[0] == 1'b0)
            stride = stride + 1;
        idx = start;
        if (op == OP_INSERT)
        begin
            if (live_count >= n)
                return a;
            guard = 0;
            while (slot_mem[idx] == SLOT_OCCUPIED)
            begin
                if (key_mem[idx] == key || guard >= n)
                    return a;
                idx = (idx + stride) % n;
                if (idx == start)
                    return a;
                guard++;
            end
            slot_mem[idx] = SLOT_OCCUPIED;
            key_mem[idx]  = key;
            val_mem[idx]  = payload;
            live_count++;
            a.status = RES_SUCCESS;
            return a;
        end
        if (op == OP_NONE)
            return a;
        if (live_count == 0)
        begin
            a.status = (op == OP_SEARCH) ? RES_NOT_FOUND : RES_FAILURE;
            return a;
        end
        for (guard = 0; guard <= n; guard++)
        begin
            if (slot_mem[idx] == SLOT_EMPTY)
                break;
            if (slot_mem[idx] == SLOT_OCCUPIED && key_mem[idx] == key)
            begin
                hit = 1'b1;
                break;
            end
            idx = (idx + stride) % n;
            if (idx == start)
            begin
                a.status = RES_NOT_FOUND;
                return a;
            end
        end
        if (op == OP_SEARCH)
        begin
            if (hit)
            begin
                a.status = RES_FOUND;
                a.slot   = idx[9:0];
                a.value  = val_mem[idx];
            end
            else
                a.status = RES_NOT_FOUND;
            return a;
        end
        if (hit)
        begin
            slot_mem[idx] = SLOT_DELETED;
            val_mem[idx]  = '0;
            live_count--;
            a.status = RES_SUCCESS;
        end
        return a;
    endfunction

    task automatic send_word(request_t r);
        answer_t a;
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, r.payload, r.key, r.op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        a = table_lookup(r.op, r.key, r.payload);
        if (r.known && (a.status != r.status || a.slot != r.slot || a.value != r.value))
            $display("%0t table row disagrees: expected %0d/%0d/%h, model %0d/%0d/%h",
                     $time, r.status, r.slot, r.value, a.status, a.slot, a.value);
        if (r.known)
        begin
            a.status = r.status;
            a.slot   = r.slot;
            a.value  = r.value;
        end
        pending_answers.push_back(a);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
    endtask

    task automatic write_size(logic [10:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= {21'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_reg = value;
    endtask

    function automatic request_t make_req(opcode_t op, logic [33:0] key, logic [63:0] payload);
        request_t r;
        r.op = op;
        r.key = key;
        r.payload = payload;
        r.known = 1'b0;
        r.status = RES_FAILURE;
        r.slot = '0;
        r.value = '0;
        return r;
    endfunction

    function automatic request_t make_known(opcode_t op, logic [33:0] key, logic [63:0] payload,
                                            result_t st, logic [9:0] sl, logic [63:0] v);
        request_t r;
        r = make_req(op, key, payload);
        r.known = 1'b1;
        r.status = st;
        r.slot = sl;
        r.value = v;
        return r;
    endfunction

    function automatic logic [33:0] random_key();
        return {2'($urandom_range(3)), $urandom()};
    endfunction

    task automatic random_phase(int count, int pool);
        request_t    r;
        logic [33:0] k;
        int          pick;
        key_pool.delete();
        for (int i = 0; i < pool; i++)
            key_pool.push_back(($urandom_range(9) == 0) ? random_key()
                               : 34'($urandom_range(4 * size_reg + 3)));
        for (int i = 0; i < count; i++)
        begin
            k = key_pool[$urandom_range(pool - 1)];
            pick = $urandom_range(99);
            if (pick < 3)
                r = make_req(OP_NONE, random_key(), {$urandom(), $urandom()});
            else if (pick < 8)
                r = make_req(opcode_t'($urandom_range(2)), random_key(), {$urandom(), $urandom()});
            else if (pick < 48)
                r = make_req(OP_INSERT, k, {$urandom(), $urandom()});
            else if (pick < 78)
                r = make_req(OP_SEARCH, k, {$urandom(), $urandom()});
            else
                r = make_req(OP_REMOVE, k, {$urandom(), $urandom()});
            send_word(r);
            if (i == count / 2)
                drain();
        end
    endtask

    always @(posedge clk)
    begin
        answer_t exp_a;
        m_tready <= (recv_idle > 0 && $urandom_range(99) < recv_idle) ? 1'b0 : 1'b1;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t unexpected word %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                exp_a = pending_answers.pop_front();
                if (m_tdata[1:0] != exp_a.status)
                begin
                    $display("%0t status expected %0d actual %0d", $time, exp_a.status,
                             m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[11:2] != exp_a.slot)
                begin
                    $display("%0t slot_index expected %0d actual %0d", $time, exp_a.slot,
                             m_tdata[11:2]);
                    errors++;
                end
                if (m_tdata[75:12] != exp_a.value)
                begin
                    $display("%0t found_value expected %h actual %h", $time, exp_a.value,
                             m_tdata[75:12]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        request_t rows[$];
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        send_idle = 12;
        recv_idle = 75;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            slot_mem[i] = SLOT_EMPTY;
            key_mem[i] = '0;
            val_mem[i] = '0;
        end
        live_count = 0;
        size_reg = 11'd1024;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(make_known(OP_SEARCH, 34'd5, '1, RES_NOT_FOUND, 10'd0, 64'd0));
        rows.push_back(make_known(OP_REMOVE, 34'd5, '0, RES_FAILURE, 10'd0, 64'd0));
        rows.push_back(make_known(OP_NONE, '1, '1, RES_FAILURE, 10'd0, 64'd0));
        rows.push_back(make_known(OP_INSERT, 34'h3FFFFFFFF, '1, RES_SUCCESS, 10'd0, 64'd0));
        rows.push_back(make_known(OP_INSERT, 34'h3FFFFFFFF, '0, RES_FAILURE, 10'd0, 64'd0));
        rows.push_back(make_known(OP_INSERT, 34'd0, 64'h0123456789ABCDEF,
                                  RES_SUCCESS, 10'd0, 64'd0));
        rows.push_back(make_known(OP_SEARCH, 34'd0, '0, RES_FOUND, 10'd0,
                                  64'h0123456789ABCDEF));
        rows.push_back(make_req(OP_SEARCH, 34'h3FFFFFFFF, '0));
        rows.push_back(make_req(OP_INSERT, 34'd1024, 64'hAAAAAAAAAAAAAAAA));
        rows.push_back(make_req(OP_INSERT, 34'd2048, 64'h5555555555555555));
        rows.push_back(make_req(OP_SEARCH, 34'd2048, '0));
        rows.push_back(make_req(OP_REMOVE, 34'd1024, '0));
        rows.push_back(make_req(OP_SEARCH, 34'd2048, '0));
        rows.push_back(make_req(OP_REMOVE, 34'd1024, '0));
        rows.push_back(make_req(OP_INSERT, 34'd1024, 64'd7));
        rows.push_back(make_req(OP_SEARCH, 34'd3072, '0));
        foreach (rows[i])
            send_word(rows[i]);
        drain();

        write_size(11'd1);
        send_word(make_req(OP_INSERT, 34'd9, 64'd1));
        send_word(make_req(OP_SEARCH, 34'd9, '0));
        send_word(make_req(OP_INSERT, 34'd3, 64'd2));
        send_word(make_req(OP_REMOVE, 34'd9, '0));
        drain();
        write_size(11'd0);
        send_word(make_req(OP_INSERT, 34'd4, 64'd3));
        send_word(make_req(OP_SEARCH, 34'd4, '0));
        drain();
        write_size(11'd2047);
        send_word(make_req(OP_SEARCH, 34'd4, '0));
        drain();

        write_size(11'd7);
        random_phase(300, 14);
        drain();
        send_idle = 75;
        recv_idle = 12;
        write_size(11'd16);
        random_phase(300, 30);
        drain();
        write_size(11'd2);
        random_phase(200, 6);
        drain();
        send_idle = 0;
        recv_idle = 0;
        write_size(11'd1024);
        random_phase(400, 200);
        drain();
        write_size(11'($urandom_range(3, 64)));
        random_phase(300, 40);
        drain();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
sv/dhoat_pkg.sv
sv/dhoat_datapath.sv
sv/dhoat_ctrl.sv
sv/double_hash_open_address_table_unit.sv
sv/dhoat_checker.sv
tb/tb_top.sv
